>>> rtl/tbfb_pkg.sv
// Package for the packed 2-bit-per-pixel framebuffer block.
// Holds panel geometry, field widths, action codes and the shared types.
// Depends on nothing; every other file of the block uses it.
package tbfb_pkg;

   // Panel geometry and store size.
   localparam int PANEL_WIDTH   = 792;
   localparam int PANEL_HEIGHT  = 272;
   localparam int BYTES_PER_ROW = (PANEL_WIDTH + 3) / 4;
   localparam int STORE_DEPTH   = BYTES_PER_ROW * PANEL_HEIGHT;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);

   // Request and response field widths.
   localparam int ACTION_W = 2;
   localparam int COL_W    = 10;
   localparam int ROW_W    = 9;
   localparam int DATA_W   = 8;
   localparam int SLOT_W   = 2;
   localparam int PIX_W    = 2;
   localparam int LANES    = 8;

   // Byte index within a row and clear row count.
   localparam int BYTE_W = (COL_W - 2 > $clog2(BYTES_PER_ROW + 1)) ?
                           COL_W - 2 : $clog2(BYTES_PER_ROW + 1);
   localparam int CNT_W  = (ROW_W > $clog2(PANEL_HEIGHT + 1)) ?
                           ROW_W : $clog2(PANEL_HEIGHT + 1);

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Action codes of a request.
   localparam logic [ACTION_W-1:0] ACT_WRITE = ACTION_W'(0);
   localparam logic [ACTION_W-1:0] ACT_CLEAR = ACTION_W'(1);
   localparam logic [ACTION_W-1:0] ACT_READ  = ACTION_W'(2);

   // Byte constants.
   localparam logic [DATA_W-1:0] PIX_MASK  = 8'hC0;
   localparam logic [DATA_W-1:0] FILL_BYTE = 8'hFF;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_CLEAR,
      CMD_READ
   } tbfb_kind_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WR_MOD,
      BK_CLR,
      BK_RD_HI,
      BK_RD_FIN
   } tbfb_back_state_type;

   // Classified request held in the front stage.
   typedef struct packed {
      tbfb_kind_type     kind;
      logic [ROW_W-1:0]  row;
      logic [BYTE_W-1:0] byte_lo;
      logic [BYTE_W-1:0] byte_hi;
      logic [CNT_W-1:0]  rows;
      logic [PIX_W-1:0]  pix;
      logic [SLOT_W-1:0] slot;
      logic              plane;
      logic [LANES-1:0]  mask;
   } tbfb_front_item_type;

   // Command handed to the back through the queue.
   typedef struct packed {
      tbfb_kind_type     kind;
      logic [ADDR_W-1:0] base;
      logic [BYTE_W-1:0] byte_lo;
      logic [BYTE_W-1:0] byte_hi;
      logic [CNT_W-1:0]  rows;
      logic [PIX_W-1:0]  pix;
      logic [SLOT_W-1:0] slot;
      logic              plane;
      logic [LANES-1:0]  mask;
   } tbfb_cmd_type;

   typedef struct packed {
      tbfb_back_state_type state;
   } tbfb_back_status_type;

endpackage

>>> rtl/tbfb_if.sv
// Valid/ready channel interfaces of the framebuffer block.
// Depends on tbfb_pkg for the field widths.
interface tbfb_req_if;
   logic                          valid;
   logic                          ready;
   logic [tbfb_pkg::ACTION_W-1:0] action;
   logic [tbfb_pkg::COL_W-1:0]    col;
   logic [tbfb_pkg::ROW_W-1:0]    row;
   logic [tbfb_pkg::COL_W-1:0]    col_stop;
   logic [tbfb_pkg::ROW_W-1:0]    row_stop;
   logic [tbfb_pkg::DATA_W-1:0]   source_byte;
   logic [tbfb_pkg::SLOT_W-1:0]   source_slot;
   logic                          plane;

   modport source (output valid, action, col, row, col_stop, row_stop,
                   source_byte, source_slot, plane, input ready);
   modport sink (input valid, action, col, row, col_stop, row_stop,
                 source_byte, source_slot, plane, output ready);
endinterface

interface tbfb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tbfb_pkg::DATA_W-1:0] plane_byte;

   modport source (output valid, plane_byte, input ready);
   modport sink (input valid, plane_byte, output ready);
endinterface

>>> rtl/tbfb_front.sv
// Front stage: accepts requests, drops the ones that do nothing, clips
// rectangles and turns the row into a store base address.
// Depends on tbfb_pkg and tbfb_if.
module tbfb_front (
   input  logic                   clock,
   input  logic                   reset,
   tbfb_req_if.sink               req_ch,
   output logic                   push_valid,
   input  logic                   push_ready,
   output tbfb_pkg::tbfb_cmd_type push_data
);

   logic                          f_valid_ff;
   logic                          f_valid_in;
   tbfb_pkg::tbfb_front_item_type f_item_ff;
   tbfb_pkg::tbfb_front_item_type f_item_in;
   logic                          accept;
   logic                          keep;

   assign req_ch.ready = !f_valid_ff || push_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      logic [tbfb_pkg::BYTE_W-1:0] b0;
      logic [tbfb_pkg::BYTE_W-1:0] b1_raw;
      logic [tbfb_pkg::BYTE_W-1:0] b1;
      logic [tbfb_pkg::CNT_W-1:0]  r0;
      logic [tbfb_pkg::CNT_W-1:0]  r1;
      logic [tbfb_pkg::COL_W-1:0]  gcol;
      logic                        row_ok;
      logic                        col_ok;
      logic                        full;

      b0     = tbfb_pkg::BYTE_W'(req_ch.col[tbfb_pkg::COL_W-1:2]);
      b1_raw = tbfb_pkg::BYTE_W'(req_ch.col_stop[tbfb_pkg::COL_W-1:2]);
      b1     = (int'(b1_raw) > tbfb_pkg::BYTES_PER_ROW) ?
               tbfb_pkg::BYTE_W'(tbfb_pkg::BYTES_PER_ROW) : b1_raw;
      r0     = tbfb_pkg::CNT_W'(req_ch.row);
      r1     = (int'(req_ch.row_stop) > tbfb_pkg::PANEL_HEIGHT) ?
               tbfb_pkg::CNT_W'(tbfb_pkg::PANEL_HEIGHT) :
               tbfb_pkg::CNT_W'(req_ch.row_stop);
      gcol   = {req_ch.col[tbfb_pkg::COL_W-1:3], 3'b000};
      row_ok = int'(req_ch.row) < tbfb_pkg::PANEL_HEIGHT;
      col_ok = int'(req_ch.col) < tbfb_pkg::PANEL_WIDTH;
      full   = (req_ch.col == req_ch.col_stop) && (req_ch.row == req_ch.row_stop);

      f_item_in.kind    = tbfb_pkg::CMD_WRITE;
      f_item_in.row     = req_ch.row;
      f_item_in.byte_lo = b0;
      f_item_in.byte_hi = b1;
      f_item_in.rows    = r1 - r0;
      f_item_in.slot    = req_ch.col[1:0];
      f_item_in.plane   = req_ch.plane;
      f_item_in.mask    = '0;
      unique case (req_ch.source_slot)
         2'd0:    f_item_in.pix = req_ch.source_byte[7:6];
         2'd1:    f_item_in.pix = req_ch.source_byte[5:4];
         2'd2:    f_item_in.pix = req_ch.source_byte[3:2];
         default: f_item_in.pix = req_ch.source_byte[1:0];
      endcase
      for (int k = 0; k < tbfb_pkg::LANES; k++) begin
         f_item_in.mask[tbfb_pkg::LANES-1-k] =
            row_ok && ((int'(gcol) + k) < tbfb_pkg::PANEL_WIDTH);
      end
      keep = 1'b0;

      unique case (req_ch.action)
         tbfb_pkg::ACT_WRITE: begin
            keep = row_ok && col_ok;
         end
         tbfb_pkg::ACT_CLEAR: begin
            f_item_in.kind = tbfb_pkg::CMD_CLEAR;
            if (full) begin
               // Start equal to end means the whole store.
               f_item_in.row     = '0;
               f_item_in.byte_lo = '0;
               f_item_in.byte_hi = tbfb_pkg::BYTE_W'(tbfb_pkg::BYTES_PER_ROW);
               f_item_in.rows    = tbfb_pkg::CNT_W'(tbfb_pkg::PANEL_HEIGHT);
               keep              = 1'b1;
            end else begin
               keep = (b0 < b1) && (r0 < r1);
            end
         end
         tbfb_pkg::ACT_READ: begin
            f_item_in.kind    = tbfb_pkg::CMD_READ;
            f_item_in.byte_lo = tbfb_pkg::BYTE_W'({req_ch.col[tbfb_pkg::COL_W-1:3], 1'b0});
            if (!row_ok) begin
               f_item_in.row = '0;
            end
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase

      if (accept) begin
         f_valid_in = keep;
      end else if (push_ready) begin
         f_valid_in = 1'b0;
      end else begin
         f_valid_in = f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_item_ff <= f_item_in;
      end
   end

   assign push_valid        = f_valid_ff;
   assign push_data.kind    = f_item_ff.kind;
   assign push_data.base    = tbfb_pkg::ADDR_W'(f_item_ff.row) *
                              tbfb_pkg::ADDR_W'(tbfb_pkg::BYTES_PER_ROW);
   assign push_data.byte_lo = f_item_ff.byte_lo;
   assign push_data.byte_hi = f_item_ff.byte_hi;
   assign push_data.rows    = f_item_ff.rows;
   assign push_data.pix     = f_item_ff.pix;
   assign push_data.slot    = f_item_ff.slot;
   assign push_data.plane   = f_item_ff.plane;
   assign push_data.mask    = f_item_ff.mask;

endmodule

>>> rtl/tbfb_queue.sv
// Short command queue between the front and the back.
// Depends on tbfb_pkg.
module tbfb_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   output logic                          push_ready,
   input  tbfb_pkg::tbfb_cmd_type        push_data,
   output logic                          pop_valid,
   input  logic                          pop_ready,
   output tbfb_pkg::tbfb_cmd_type        pop_data,
   output logic [tbfb_pkg::QCNT_W-1:0]   count
);

   tbfb_pkg::tbfb_cmd_type              entry_ff [tbfb_pkg::QUEUE_DEPTH];
   logic [tbfb_pkg::QPTR_W-1:0]         wr_ptr_ff;
   logic [tbfb_pkg::QPTR_W-1:0]         wr_ptr_in;
   logic [tbfb_pkg::QPTR_W-1:0]         rd_ptr_ff;
   logic [tbfb_pkg::QPTR_W-1:0]         rd_ptr_in;
   logic [tbfb_pkg::QCNT_W-1:0]         count_ff;
   logic [tbfb_pkg::QCNT_W-1:0]         count_in;
   logic                                do_push;
   logic                                do_pop;

   assign push_ready = count_ff != tbfb_pkg::QCNT_W'(tbfb_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == tbfb_pkg::QUEUE_DEPTH - 1) ?
                     '0 : wr_ptr_ff + tbfb_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == tbfb_pkg::QUEUE_DEPTH - 1) ?
                     '0 : rd_ptr_ff + tbfb_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + tbfb_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - tbfb_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/tbfb_back.sv
// Back end: owns the pixel store and carries out writes, clears and reads,
// with a one-entry response register on the output.
// Depends on tbfb_pkg and tbfb_if.
module tbfb_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   output logic                           cmd_ready,
   input  tbfb_pkg::tbfb_cmd_type         cmd,
   tbfb_rsp_if.source                     rsp_ch,
   output tbfb_pkg::tbfb_back_status_type status
);

   // Pixel store, contents undefined until written.
   logic [tbfb_pkg::DATA_W-1:0] mem [tbfb_pkg::STORE_DEPTH];
   logic [tbfb_pkg::DATA_W-1:0] rd_data_ff;
   logic                        mem_re;
   logic [tbfb_pkg::ADDR_W-1:0] mem_raddr;
   logic                        mem_we;
   logic [tbfb_pkg::ADDR_W-1:0] mem_waddr;
   logic [tbfb_pkg::DATA_W-1:0] mem_wdata;

   tbfb_pkg::tbfb_back_state_type state_ff, state_in;
   logic [tbfb_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [tbfb_pkg::ADDR_W-1:0]   base_ff, base_in;
   logic [tbfb_pkg::BYTE_W-1:0]   byte_ff, byte_in;
   logic [tbfb_pkg::BYTE_W-1:0]   byte_lo_ff, byte_lo_in;
   logic [tbfb_pkg::BYTE_W-1:0]   byte_hi_ff, byte_hi_in;
   logic [tbfb_pkg::CNT_W-1:0]    rows_ff, rows_in;
   logic [tbfb_pkg::PIX_W-1:0]    pix_ff, pix_in;
   logic [tbfb_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic                          plane_ff, plane_in;
   logic [tbfb_pkg::LANES-1:0]    mask_ff, mask_in;
   logic [tbfb_pkg::DATA_W-1:0]   lo_data_ff, lo_data_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tbfb_pkg::DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // Pick one bit of each of the eight pixels held in two adjacent bytes.
   function automatic logic [tbfb_pkg::DATA_W-1:0] gather(
      input logic [tbfb_pkg::DATA_W-1:0] lo,
      input logic [tbfb_pkg::DATA_W-1:0] hi,
      input logic                        pl
   );
      logic [tbfb_pkg::DATA_W-1:0] r;
      for (int k = 0; k < 4; k++) begin
         r[7-k] = pl ? lo[6-2*k] : lo[7-2*k];
         r[3-k] = pl ? hi[6-2*k] : hi[7-2*k];
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      logic [tbfb_pkg::BYTE_W-1:0] byte_nx;

      state_in     = state_ff;
      addr_in      = addr_ff;
      base_in      = base_ff;
      byte_in      = byte_ff;
      byte_lo_in   = byte_lo_ff;
      byte_hi_in   = byte_hi_ff;
      rows_in      = rows_ff;
      pix_in       = pix_ff;
      slot_in      = slot_ff;
      plane_in     = plane_ff;
      mask_in      = mask_ff;
      lo_data_in   = lo_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      cmd_ready    = 1'b0;
      mem_re       = 1'b0;
      mem_raddr    = cmd.base + tbfb_pkg::ADDR_W'(cmd.byte_lo);
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = tbfb_pkg::FILL_BYTE;
      byte_nx      = byte_ff + tbfb_pkg::BYTE_W'(1);

      unique case (state_ff)
         tbfb_pkg::BK_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               addr_in    = cmd.base + tbfb_pkg::ADDR_W'(cmd.byte_lo);
               base_in    = cmd.base;
               byte_in    = cmd.byte_lo;
               byte_lo_in = cmd.byte_lo;
               byte_hi_in = cmd.byte_hi;
               rows_in    = cmd.rows;
               pix_in     = cmd.pix;
               slot_in    = cmd.slot;
               plane_in   = cmd.plane;
               mask_in    = cmd.mask;
               unique case (cmd.kind)
                  tbfb_pkg::CMD_WRITE: begin
                     mem_re   = 1'b1;
                     state_in = tbfb_pkg::BK_WR_MOD;
                  end
                  tbfb_pkg::CMD_CLEAR: begin
                     state_in = tbfb_pkg::BK_CLR;
                  end
                  tbfb_pkg::CMD_READ: begin
                     mem_re   = 1'b1;
                     state_in = tbfb_pkg::BK_RD_HI;
                  end
                  default: begin
                     state_in = tbfb_pkg::BK_IDLE;
                  end
               endcase
            end
         end
         tbfb_pkg::BK_WR_MOD: begin
            mem_we    = 1'b1;
            mem_wdata = (rd_data_ff & ~(tbfb_pkg::PIX_MASK >> {slot_ff, 1'b0})) |
                        (tbfb_pkg::DATA_W'(pix_ff) << {~slot_ff, 1'b0});
            state_in  = tbfb_pkg::BK_IDLE;
         end
         tbfb_pkg::BK_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = base_ff + tbfb_pkg::ADDR_W'(byte_ff);
            if (byte_nx == byte_hi_ff) begin
               byte_in = byte_lo_ff;
               base_in = base_ff + tbfb_pkg::ADDR_W'(tbfb_pkg::BYTES_PER_ROW);
               rows_in = rows_ff - tbfb_pkg::CNT_W'(1);
               if (rows_ff == tbfb_pkg::CNT_W'(1)) begin
                  state_in = tbfb_pkg::BK_IDLE;
               end
            end else begin
               byte_in = byte_nx;
            end
         end
         tbfb_pkg::BK_RD_HI: begin
            mem_re     = 1'b1;
            mem_raddr  = addr_ff + tbfb_pkg::ADDR_W'(1);
            lo_data_in = rd_data_ff;
            state_in   = tbfb_pkg::BK_RD_FIN;
         end
         tbfb_pkg::BK_RD_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = gather(lo_data_ff, rd_data_ff, plane_ff) & mask_ff;
               state_in     = tbfb_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = tbfb_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbfb_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      base_ff     <= base_in;
      byte_ff     <= byte_in;
      byte_lo_ff  <= byte_lo_in;
      byte_hi_ff  <= byte_hi_in;
      rows_ff     <= rows_in;
      pix_ff      <= pix_in;
      slot_ff     <= slot_in;
      plane_ff    <= plane_in;
      mask_ff     <= mask_in;
      lo_data_ff  <= lo_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.plane_byte = rsp_data_ff;
   assign status.state      = state_ff;

endmodule

>>> rtl/two_bit_framebuffer_blit_plane_read.sv
// Top level of the packed 2-bit-per-pixel framebuffer block.
// Instantiates tbfb_front, tbfb_queue and tbfb_back; uses tbfb_pkg and tbfb_if.
//
//   Channel  Direction  Carries
//   req_ch   in         action, col, row, col_stop, row_stop, source_byte,
//                       source_slot, plane
//   rsp_ch   out        plane_byte, one per plane read request
//
// The front takes one request per cycle, unless the queue is full, into a
// two-entry queue. In the back a pixel write reads its byte, then modifies and
// writes it; a plane read makes two byte reads and a gather; a clear fills its
// bytes one after another, all 53856 for a full clear. The single port pair of
// the pixel store sets these steps. Reset clears the control state only; the
// store contents stay undefined until written. A stalled response holds the
// back in its last read step, and a full queue holds the front stage.
module two_bit_framebuffer_blit_plane_read (
   input logic        clock,
   input logic        reset,
   tbfb_req_if.sink   req_ch,
   tbfb_rsp_if.source rsp_ch
);

   // Front to queue.
   logic                           push_valid;
   logic                           push_ready;
   tbfb_pkg::tbfb_cmd_type         push_data;

   // Queue to back.
   logic                           cmd_valid;
   logic                           cmd_ready;
   tbfb_pkg::tbfb_cmd_type         cmd;
   logic [tbfb_pkg::QCNT_W-1:0]    q_count;

   tbfb_pkg::tbfb_back_status_type back_status;

   // The front decodes and clips each request; no-op requests (the unused
   // action code, off-panel writes and empty rectangles) are dropped here.
   tbfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // The queue lets the front keep taking requests while a long clear runs.
   tbfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (cmd_valid),
      .pop_ready  (cmd_ready),
      .pop_data   (cmd),
      .count      (q_count)
   );

   // The back owns the store and executes one command at a time.
   tbfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_ch    (rsp_ch),
      .status    (back_status)
   );

   // A response appears only out of the final step of a plane read.
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(back_status.state == tbfb_pkg::BK_RD_FIN))
      else $error("response raised outside a plane read");

   // The front stage keeps its command while the queue is full.
   a_front_holds: assert property (@(posedge clock) disable iff (reset)
      push_valid && !push_ready |=> push_valid)
      else $error("front stage dropped a command");

   // The queue never holds more than its depth.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= tbfb_pkg::QCNT_W'(tbfb_pkg::QUEUE_DEPTH))
      else $error("queue overfilled");

   // The write half of a read-modify-write follows its read directly.
   a_rmw_pair: assert property (@(posedge clock) disable iff (reset)
      back_status.state == tbfb_pkg::BK_WR_MOD |->
         $past(back_status.state == tbfb_pkg::BK_IDLE))
      else $error("pixel write without its byte read");

endmodule

>>> tb/sv/tb_fb_mirror_pkg.sv
// Scoreboard package for the packed 2-bit-per-pixel framebuffer testbench.
// Holds the request record, a shadow copy of the pixel store and the plane byte checks.
// Depends on tbfb_pkg for the panel geometry, field widths and action codes.
package tb_fb_mirror_pkg;
   import tbfb_pkg::*;

   // The block ignores the one action code that the package leaves unnamed.
   localparam logic [ACTION_W-1:0] ACT_SPARE = ACTION_W'(3);

   // Plane select and the pixel bit that each plane picks.
   localparam logic              PLANE_HI    = 1'b0;
   localparam logic              PLANE_LO    = 1'b1;
   localparam logic [DATA_W-1:0] HI_BIT_MASK = 8'h80;
   localparam logic [DATA_W-1:0] LO_BIT_MASK = 8'h40;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [COL_W-1:0]    col;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    col_stop;
      logic [ROW_W-1:0]    row_stop;
      logic [DATA_W-1:0]   source_byte;
      logic [SLOT_W-1:0]   source_slot;
      logic                plane;
   } fb_request_type;

   class framebuffer_mirror;
      logic [DATA_W-1:0] mirror_pixels [STORE_DEPTH];
      logic [DATA_W-1:0] expected_plane_bytes [$];
      int unsigned       mismatches;
      int unsigned       plane_bytes_checked;

      function new();
         foreach (mirror_pixels[i]) mirror_pixels[i] = '0;
         mismatches          = 0;
         plane_bytes_checked = 0;
      endfunction

      function int unsigned pending();
         return expected_plane_bytes.size();
      endfunction

      // Applies one accepted request to the shadow store; a plane read also
      // queues the byte that the block must return for it.
      function void take_request(fb_request_type r);
         int                c;
         int                rw;
         int                pix;
         int                idx;
         int                b0;
         int                b1;
         int                r1;
         int                base;
         logic [DATA_W-1:0] v;
         logic [DATA_W-1:0] mask;
         logic [DATA_W-1:0] acc;
         c  = int'(r.col);
         rw = int'(r.row);
         case (r.action)
            ACT_WRITE: begin
               if (c < PANEL_WIDTH && rw < PANEL_HEIGHT) begin
                  pix = (int'(r.source_byte) >> (6 - 2 * int'(r.source_slot))) & 3;
                  idx = rw * BYTES_PER_ROW + c / 4;
                  mirror_pixels[idx] = (mirror_pixels[idx] & ~(PIX_MASK >> (2 * (c % 4))))
                                     | DATA_W'(pix << (6 - 2 * (c % 4)));
               end
            end
            ACT_CLEAR: begin
               if (r.col == r.col_stop && r.row == r.row_stop) begin
                  foreach (mirror_pixels[i]) mirror_pixels[i] = FILL_BYTE;
               end else begin
                  // Columns are cut to whole bytes, and the rectangle is clipped
                  // so that it never wraps into the next row.
                  b0 = c / 4;
                  b1 = int'(r.col_stop) / 4;
                  r1 = int'(r.row_stop);
                  if (b1 > BYTES_PER_ROW) b1 = BYTES_PER_ROW;
                  if (r1 > PANEL_HEIGHT) r1 = PANEL_HEIGHT;
                  for (int y = rw; y < r1; y++)
                     for (int b = b0; b < b1; b++)
                        mirror_pixels[y * BYTES_PER_ROW + b] = FILL_BYTE;
               end
            end
            ACT_READ: begin
               base = c & ~7;
               mask = (r.plane == PLANE_LO) ? LO_BIT_MASK : HI_BIT_MASK;
               acc  = '0;
               for (int k = 0; k < LANES; k++) begin
                  v = '0;
                  if (base + k < PANEL_WIDTH && rw < PANEL_HEIGHT) begin
                     v = mirror_pixels[rw * BYTES_PER_ROW + (base + k) / 4]
                         << (2 * ((base + k) % 4));
                  end
                  acc = {acc[DATA_W-2:0], ((v & mask) != '0)};
               end
               expected_plane_bytes.push_back(acc);
            end
            default: ;
         endcase
      endfunction

      function void check_plane_byte(logic [DATA_W-1:0] actual, longint unsigned now_ns);
         logic [DATA_W-1:0] wanted;
         if (expected_plane_bytes.size() == 0) begin
            $display("%0d ns: plane_byte 0x%02h arrived with none expected, actual 0x%02h",
                     now_ns, actual, actual);
            mismatches++;
            return;
         end
         wanted = expected_plane_bytes.pop_front();
         plane_bytes_checked++;
         if (actual !== wanted) begin
            $display("%0d ns: plane_byte mismatch, expected 0x%02h, actual 0x%02h",
                     now_ns, wanted, actual);
            mismatches++;
         end
      endfunction
   endclass

endpackage

>>> tb/sv/tb_two_bit_framebuffer_blit_plane_read.sv
// Top-level testbench for the packed 2-bit-per-pixel framebuffer block.
// Drives requests, checks every plane byte against a shadow store and ends the run.
// Depends on tbfb_pkg, the tbfb_if channel interfaces and tb_fb_mirror_pkg.
module tb_two_bit_framebuffer_blit_plane_read;
   timeunit 1ns;
   timeprecision 1ps;

   import tbfb_pkg::*;
   import tb_fb_mirror_pkg::*;

   // The slowest legal run is a handful of full clears plus every request waiting
   // out both sides idling; the limit is several times that.
   localparam int unsigned CYCLE_LIMIT      = 2_000_000;
   localparam int unsigned RANDOM_PER_PHASE = 220;
   localparam int unsigned HOLDOFF_CYCLES   = 400;
   localparam int unsigned PRESSURE_READS   = 24;
   localparam int unsigned TAIL_CYCLES      = 64;

   logic clock = 1'b0;
   logic reset;

   tbfb_req_if req_ch ();
   tbfb_rsp_if rsp_ch ();

   two_bit_framebuffer_blit_plane_read u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   framebuffer_mirror mirror = new();

   // Idle rates in percent, changed by the stimulus between phases.
   int unsigned send_idle_pct      = 0;
   int unsigned recv_idle_pct      = 50;
   // Set by the stimulus, counted down by the response side.
   int unsigned rsp_holdoff_cycles = 0;
   int unsigned cycle_count        = 0;

   int unsigned writes_sent = 0;
   int unsigned clears_sent = 0;
   int unsigned reads_sent  = 0;
   int unsigned spare_sent  = 0;

   // Locality for the random part: most requests land in a small window of
   // rows and columns so that reads see the pixels that writes just placed.
   int unsigned hot_row  = 0;
   int unsigned hot_col  = 0;
   int unsigned last_col = 0;
   int unsigned last_row = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog. A hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Watchdog expired after %0d cycles with %0d plane bytes outstanding.",
                  cycle_count, mirror.pending());
         $display("tb: failure");
         $finish;
      end
   end

   // Response side. Values are sampled right at the rising edge, so a
   // response counts as taken exactly when valid and ready were both high
   // before the edge. Ready for the next cycle is then chosen at random, or
   // held low while a hold-off is running.
   initial begin : rsp_side
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            mirror.check_plane_byte(rsp_ch.plane_byte, $time);
         end
         if (rsp_holdoff_cycles > 0) begin
            rsp_holdoff_cycles = rsp_holdoff_cycles - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic fb_request_type compose_request(
      input logic [ACTION_W-1:0] action,
      input int unsigned         col,
      input int unsigned         row,
      input int unsigned         col_stop,
      input int unsigned         row_stop,
      input int unsigned         source_byte,
      input int unsigned         source_slot,
      input logic                plane
   );
      fb_request_type r;
      r.action      = action;
      r.col         = COL_W'(col);
      r.row         = ROW_W'(row);
      r.col_stop    = COL_W'(col_stop);
      r.row_stop    = ROW_W'(row_stop);
      r.source_byte = DATA_W'(source_byte);
      r.source_slot = SLOT_W'(source_slot);
      r.plane       = plane;
      return r;
   endfunction

   // Offers one request, possibly after some idle cycles, and waits for the
   // block to take it. Valid stays high after acceptance, so a following
   // request goes out back to back unless an idle cycle is chosen.
   task automatic offer_request(input fb_request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= r.action;
      req_ch.col         <= r.col;
      req_ch.row         <= r.row;
      req_ch.col_stop    <= r.col_stop;
      req_ch.row_stop    <= r.row_stop;
      req_ch.source_byte <= r.source_byte;
      req_ch.source_slot <= r.source_slot;
      req_ch.plane       <= r.plane;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      mirror.take_request(r);
      case (r.action)
         ACT_WRITE: writes_sent++;
         ACT_CLEAR: clears_sent++;
         ACT_READ:  reads_sent++;
         default:   spare_sent++;
      endcase
   endtask

   // The sender stops and waits until every plane byte owed has come back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (mirror.pending() != 0) @(posedge clock);
   endtask

   // Builds one random request. Most are well-formed writes, reads and small
   // clears inside the hot window; a few are large or clipped clears, inverted
   // rectangles, the spare action code and requests off the panel.
   function automatic fb_request_type next_random_request();
      fb_request_type r;
      int unsigned    pick;
      int unsigned    c0;
      int unsigned    c1;
      int unsigned    r0;
      int unsigned    r1;
      int unsigned    swap;
      if ($urandom_range(49) == 0) begin
         hot_row = $urandom_range(PANEL_HEIGHT - 4);
         hot_col = $urandom_range(PANEL_WIDTH - 64);
      end
      pick = $urandom_range(99);
      r = compose_request(ACT_WRITE, hot_col + $urandom_range(63), hot_row + $urandom_range(3),
                          $urandom_range(1023), $urandom_range(511), $urandom_range(255),
                          $urandom_range(3), 1'($urandom_range(1)));
      if (pick < 42) begin
         // Pixel write; one in eight goes anywhere on the panel.
         if ($urandom_range(7) == 0) begin
            r.col = COL_W'($urandom_range(PANEL_WIDTH - 1));
            r.row = ROW_W'($urandom_range(PANEL_HEIGHT - 1));
         end
         last_col = r.col;
         last_row = r.row;
      end else if (pick < 80) begin
         // Plane read, half of them right where the last pixel went.
         r.action = ACT_READ;
         if ($urandom_range(1) == 1) begin
            r.col = COL_W'(last_col);
            r.row = ROW_W'(last_row);
         end
      end else if (pick < 92) begin
         r.action = ACT_CLEAR;
         c0 = hot_col + $urandom_range(63);
         c1 = c0 + $urandom_range(48);
         r0 = hot_row + $urandom_range(3);
         r1 = r0 + $urandom_range(4);
         if ($urandom_range(19) == 0) begin
            // Wide clear running off the right edge and sometimes the bottom.
            c0 = $urandom_range(40);
            c1 = $urandom_range(PANEL_WIDTH, 1023);
            r1 = r0 + $urandom_range(8, 40);
         end
         if ($urandom_range(9) == 0) begin
            swap = c0;
            c0   = c1;
            c1   = swap;
         end
         // Equal corners would mean a full clear; keep those for phase starts.
         if (c0 == c1 && r0 == r1) r1 = r0 + 1;
         r.col      = COL_W'(c0);
         r.col_stop = COL_W'(c1);
         r.row      = ROW_W'(r0);
         r.row_stop = ROW_W'(r1);
      end else if (pick < 96) begin
         r.action = ACT_SPARE;
         r.col    = COL_W'($urandom_range(1023));
         r.row    = ROW_W'($urandom_range(511));
      end else begin
         // Write or read with the column or the row beyond the panel.
         r.action = ($urandom_range(1) == 1) ? ACT_READ : ACT_WRITE;
         if ($urandom_range(1) == 1) begin
            r.col = COL_W'($urandom_range(PANEL_WIDTH, 1023));
            r.row = ROW_W'($urandom_range(511));
         end else begin
            r.col = COL_W'($urandom_range(1023));
            r.row = ROW_W'($urandom_range(PANEL_HEIGHT, 511));
         end
      end
      return r;
   endfunction

   initial begin : stimulus
      fb_request_type r;
      int unsigned    counted;
      int unsigned    fc;
      int unsigned    fr;

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.action      <= '0;
      req_ch.col         <= '0;
      req_ch.row         <= '0;
      req_ch.col_stop    <= '0;
      req_ch.row_stop    <= '0;
      req_ch.source_byte <= '0;
      req_ch.source_slot <= '0;
      req_ch.plane       <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The store is undefined after reset, so the very first
      // request is a full clear, which fills every byte before any read.
      offer_request(compose_request(ACT_CLEAR, 0, 0, 0, 0, 0, 0, PLANE_HI));
      offer_request(compose_request(ACT_READ, 0, 0, 0, 0, 0, 0, PLANE_HI));
      // One byte gets all four pixel codes, each taken from a different slot.
      offer_request(compose_request(ACT_WRITE, 0, 0, 0, 0, 8'h1B, 0, PLANE_HI));
      offer_request(compose_request(ACT_WRITE, 1, 0, 0, 0, 8'h1B, 1, PLANE_HI));
      offer_request(compose_request(ACT_WRITE, 2, 0, 0, 0, 8'h1B, 2, PLANE_HI));
      offer_request(compose_request(ACT_WRITE, 3, 0, 0, 0, 8'h1B, 3, PLANE_HI));
      // A read column that is not a multiple of eight covers the aligned group.
      offer_request(compose_request(ACT_READ, 7, 0, 0, 0, 0, 0, PLANE_HI));
      offer_request(compose_request(ACT_READ, 0, 0, 0, 0, 0, 0, PLANE_LO));
      // The last pixel of the panel, then writes just past and far past it.
      offer_request(compose_request(ACT_WRITE, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 0, 0,
                                    8'hFC, 3, PLANE_HI));
      offer_request(compose_request(ACT_WRITE, 1023, 511, 1023, 511, 8'h00, 0, PLANE_LO));
      offer_request(compose_request(ACT_WRITE, PANEL_WIDTH, 0, 0, 0, 8'h00, 0, PLANE_HI));
      offer_request(compose_request(ACT_WRITE, 0, PANEL_HEIGHT, 0, 0, 8'h00, 0, PLANE_HI));
      // The last group of a row lies wholly on the panel; groups off it read as 0.
      offer_request(compose_request(ACT_READ, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 0, 0,
                                    0, 0, PLANE_HI));
      offer_request(compose_request(ACT_READ, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 0, 0,
                                    0, 0, PLANE_LO));
      offer_request(compose_request(ACT_READ, 1023, 511, 0, 0, 0, 0, PLANE_HI));
      offer_request(compose_request(ACT_READ, 800, 3, 0, 0, 0, 0, PLANE_LO));
      // Start column 3 falls into byte 0, so bytes 0 to 2 of rows 0 and 1 fill.
      offer_request(compose_request(ACT_CLEAR, 3, 0, 13, 2, 0, 0, PLANE_HI));
      offer_request(compose_request(ACT_READ, 0, 0, 0, 0, 0, 0, PLANE_LO));
      // Inverted rectangle, then one whose columns fall in a single byte.
      offer_request(compose_request(ACT_CLEAR, 100, 5, 40, 9, 0, 0, PLANE_HI));
      offer_request(compose_request(ACT_CLEAR, 4, 3, 7, 9, 0, 0, PLANE_HI));
      // A pixel in the bottom right corner, then a clear clipped at both edges.
      offer_request(compose_request(ACT_WRITE, 788, 270, 0, 0, 8'h00, 1, PLANE_HI));
      offer_request(compose_request(ACT_CLEAR, 780, 270, 1023, 511, 0, 0, PLANE_HI));
      offer_request(compose_request(ACT_READ, 784, 270, 0, 0, 0, 0, PLANE_HI));
      offer_request(compose_request(ACT_SPARE, 5, 0, 5, 0, 8'h00, 0, PLANE_HI));
      offer_request(compose_request(ACT_READ, 0, 0, 0, 0, 0, 0, PLANE_HI));
      // Equal corners away from the origin still clear the whole store.
      offer_request(compose_request(ACT_CLEAR, PANEL_WIDTH - 1, PANEL_HEIGHT - 1,
                                    PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 0, 0, PLANE_HI));
      offer_request(compose_request(ACT_READ, 784, 271, 0, 0, 0, 0, PLANE_LO));
      drain_results();

      // Random part in three phases: slow receiver, slow sender, no idling.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 26;
               recv_idle_pct = 87;
            end
            1: begin
               send_idle_pct = 87;
               recv_idle_pct = 26;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase != 0) begin
            fc = $urandom_range(1023);
            fr = $urandom_range(511);
            offer_request(compose_request(ACT_CLEAR, fc, fr, fc, fr, 0, 0, PLANE_HI));
         end
         counted = 0;
         while (counted < RANDOM_PER_PHASE) begin
            r = next_random_request();
            offer_request(r);
            // The spare code and off-panel writes do nothing, so they do not count.
            if (r.action != ACT_SPARE &&
                !(r.action == ACT_WRITE && (r.col >= PANEL_WIDTH || r.row >= PANEL_HEIGHT)))
               counted++;
         end
         drain_results();
         if (phase == 2) begin
            // Let any long clear finish: a read queued behind it returns only
            // once the back end is free. Then the receiver holds off while
            // reads keep coming, so the queue fills and the input stalls.
            offer_request(compose_request(ACT_READ, 0, 0, 0, 0, 0, 0, PLANE_HI));
            drain_results();
            rsp_holdoff_cycles = HOLDOFF_CYCLES;
            repeat (PRESSURE_READS) begin
               offer_request(compose_request(ACT_READ, $urandom_range(PANEL_WIDTH - 1),
                                             $urandom_range(PANEL_HEIGHT - 1), 0, 0, 0, 0,
                                             1'($urandom_range(1))));
            end
            drain_results();
         end
      end

      // A clear owes no result, so give the block time to show a stray one.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mirror.pending() != 0) begin
         $display("%0d ns: %0d plane bytes still expected at the end of the run",
                  $time, mirror.pending());
      end

      $display("Covered %0d pixel writes, %0d clears, %0d plane reads, %0d spare-code requests.",
               writes_sent, clears_sent, reads_sent, spare_sent);
      $display("Checked %0d plane bytes under three idle mixes and one long hold-off.",
               mirror.plane_bytes_checked);
      if (mirror.mismatches == 0 && mirror.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
